// ----- rtl/bcat_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the block chain allocation table
package bcat_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned BLK_W    = 12;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FORMAT = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_ENTRY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COUNT,
    S_LINK,
    S_END,
    S_FREE,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] block_index;
    logic             chain_end;
  } result_t;

endpackage

// ----- rtl/bcat_table.sv -----
`timescale 1ns / 1ps
// link table memory, one write and one registered read port with write bypass
module bcat_table
  import bcat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int unsigned IW = $clog2(TABLE_ENTRIES),
  localparam int unsigned EW = IW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic [IW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] wd_q;
  logic          hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
    wd_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = hit_q ? wd_q : rd_q;

endmodule

// ----- rtl/bcat_ctrl.sv -----
`timescale 1ns / 1ps
// command sequencer: clearing pass, allocation scans, chain walk and read
module bcat_ctrl
  import bcat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int unsigned IW = $clog2(TABLE_ENTRIES),
  localparam int unsigned EW = IW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [COUNT_W-1:0] block_count_i,
  input  logic [BLK_W-1:0]   start_block_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o,
  output logic               we_o,
  output logic [IW-1:0]      waddr_o,
  output logic [EW-1:0]      wdata_o,
  output logic [IW-1:0]      raddr_o,
  input  logic [EW-1:0]      rdata_i
);

  localparam logic [EW-1:0] END_MARK = EW'(TABLE_ENTRIES);
  localparam logic [EW-1:0] LAST     = EW'(TABLE_ENTRIES - 1);

  state_e             state_q, state_d;
  logic [EW-1:0]      addr_q, addr_d;
  logic               pv_q, pv_d;
  logic [IW-1:0]      paddr_q, paddr_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [IW-1:0]      prev_q, prev_d;
  logic               head_q, head_d;
  logic               fmt_q, fmt_d;
  result_t            res_q, res_d;

  logic               iss;
  logic               start_bad;
  logic               in_beat;

  assign iss       = (addr_q != END_MARK);
  assign start_bad = (32'(start_block_i) >= 32'(TABLE_ENTRIES));
  assign in_beat   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      pv_q    <= 1'b0;
      fmt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pv_q    <= pv_d;
      fmt_q   <= fmt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    cnt_q   <= cnt_d;
    count_q <= count_d;
    prev_q  <= prev_d;
    head_q  <= head_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    pv_d        = 1'b0;
    paddr_d     = paddr_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    prev_d      = prev_q;
    head_d      = head_q;
    fmt_d       = fmt_q;
    res_d       = res_q;
    we_o        = 1'b0;
    waddr_o     = prev_q;
    wdata_o     = '0;
    raddr_o     = addr_q[IW-1:0];
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_RESP);

    unique case (state_q)
      S_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = addr_q[IW-1:0];
        wdata_o = (addr_q == '0) ? END_MARK : '0;
        addr_d  = addr_q + EW'(1);
        if (addr_q == LAST) begin
          state_d = fmt_q ? S_RESP : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_beat) begin
          count_d = block_count_i;
          res_d   = '{status: ST_OK, block_index: '0, chain_end: 1'b0};
          unique case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              addr_d = EW'(1);
              cnt_d  = '0;
              if (block_count_i == '0) begin
                state_d = S_RESP;
              end else begin
                state_d = S_COUNT;
              end
            end
            CMD_FREE: begin
              if (start_block_i == '0 || start_bad) begin
                res_d.status = ST_BAD_ENTRY;
                state_d      = S_RESP;
              end else begin
                raddr_o = IW'(start_block_i);
                prev_d  = IW'(start_block_i);
                cnt_d   = '0;
                head_d  = 1'b1;
                state_d = S_FREE;
              end
            end
            CMD_READ: begin
              if (start_bad) begin
                res_d.status = ST_BAD_ENTRY;
                state_d      = S_RESP;
              end else begin
                raddr_o = IW'(start_block_i);
                state_d = S_READ;
              end
            end
            CMD_FORMAT: begin
              addr_d  = '0;
              fmt_d   = 1'b1;
              state_d = S_CLEAR;
            end
          endcase
        end
      end

      S_COUNT: begin
        if (iss) begin
          addr_d  = addr_q + EW'(1);
          pv_d    = 1'b1;
          paddr_d = addr_q[IW-1:0];
        end
        if (pv_q && rdata_i == '0) begin
          cnt_d = cnt_q + COUNT_W'(1);
          if (cnt_q + COUNT_W'(1) == count_q) begin
            state_d = S_LINK;
            addr_d  = EW'(1);
            pv_d    = 1'b0;
            cnt_d   = '0;
          end
        end else if (!pv_q && !iss) begin
          res_d.status = ST_NO_SPACE;
          state_d      = S_RESP;
        end
      end

      S_LINK: begin
        if (iss) begin
          addr_d  = addr_q + EW'(1);
          pv_d    = 1'b1;
          paddr_d = addr_q[IW-1:0];
        end
        if (pv_q && rdata_i == '0) begin
          if (cnt_q == '0) begin
            res_d.block_index = BLK_W'(paddr_q);
          end else begin
            we_o    = 1'b1;
            waddr_o = prev_q;
            wdata_o = EW'(paddr_q);
          end
          prev_d = paddr_q;
          cnt_d  = cnt_q + COUNT_W'(1);
          if (cnt_q + COUNT_W'(1) == count_q) begin
            pv_d    = 1'b0;
            state_d = S_END;
          end
        end
      end

      S_END: begin
        we_o    = 1'b1;
        waddr_o = prev_q;
        wdata_o = END_MARK;
        state_d = S_RESP;
      end

      S_FREE: begin
        if (rdata_i == '0) begin
          res_d.status = head_q ? ST_BAD_ENTRY : ST_OK;
          state_d      = S_RESP;
        end else if (head_q && count_q == '0) begin
          state_d = S_RESP;
        end else begin
          we_o    = 1'b1;
          waddr_o = prev_q;
          wdata_o = '0;
          head_d  = 1'b0;
          cnt_d   = cnt_q + COUNT_W'(1);
          if (rdata_i == END_MARK || cnt_q + COUNT_W'(1) == count_q) begin
            state_d = S_RESP;
          end else begin
            prev_d  = rdata_i[IW-1:0];
            raddr_o = rdata_i[IW-1:0];
          end
        end
      end

      S_READ: begin
        if (rdata_i == '0) begin
          res_d.status = ST_BAD_ENTRY;
        end else if (rdata_i == END_MARK) begin
          res_d.chain_end = 1'b1;
        end else begin
          res_d.block_index = BLK_W'(rdata_i);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          fmt_d   = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  // table untouched while waiting for a command
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we_o)
    else $error("table written while idle");

  // links only point forward to the entry being taken
  a_link_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK && we_o) |-> (waddr_o < paddr_q))
    else $error("allocation link does not point forward");

  // a delivered result frees the sequencer
  a_resp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> in_ready_o)
    else $error("sequencer not idle after result beat");

endmodule

// ----- rtl/block_chain_allocation_table.sv -----
`timescale 1ns / 1ps
// Block chain allocation table: keeps a table of TABLE_ENTRIES links, each free,
// a link to the next block or an end mark, and serves allocate, free, read and
// format commands one at a time through one write and one read table port.
// After reset and on format a clearing pass writes one entry a cycle, during
// which no command beat is taken. Allocate streams the table from entry
// 1 one entry a cycle twice, once to count free entries and once to link them,
// and stops early once enough free entries are seen. Free walks the chain at
// one entry a cycle. Results sit in an output register, so a new command is
// taken while the previous result waits.
module block_chain_allocation_table
  import bcat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [COUNT_W-1:0]  block_count_i,
  input  logic [BLK_W-1:0]    start_block_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [BLK_W-1:0]    block_index_o,
  output logic                chain_end_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW = IW + 1;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_q;
  logic          out_valid_q, out_valid_d;

  bcat_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  bcat_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .block_count_i(block_count_i),
    .start_block_i(start_block_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .rdata_i      (rdata)
  );

  // output register takes a result beat whenever it is empty or draining
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_ready ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign block_index_o = out_q.block_index;
  assign chain_end_o   = out_q.chain_end;

  // one command at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("command beat taken while busy");

endmodule

// ----- bench/tb_block_chain_allocation_table.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the block chain allocation table, directed rows then random commands
module tb_block_chain_allocation_table;
  import bcat_pkg::*;

  localparam int unsigned ENTRIES = TABLE_ENTRIES_DEF;
  localparam logic [12:0] END_MARK = 13'(ENTRIES);

  typedef struct {
    cmd_e        cmd;
    logic [11:0] cnt;
    logic [11:0] start;
    bit          typed;
    result_t     resp;
  } vec_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i;
  logic [COUNT_W-1:0] block_count_i;
  logic [BLK_W-1:0]  start_block_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [BLK_W-1:0]  block_index_o;
  logic              chain_end_o;

  logic [12:0] fat_links [ENTRIES];
  result_t     expected_responses [$];
  logic [11:0] chain_heads [$];
  vec_row_t    directed_rows [$];
  bit          no_idle;
  int          n_errors;
  int          n_sent;
  int          n_ok;
  int          n_nospace;
  int          n_bad;

  block_chain_allocation_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .block_count_i(block_count_i),
    .start_block_i(start_block_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .block_index_o(block_index_o),
    .chain_end_o  (chain_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_links();
    foreach (fat_links[i]) fat_links[i] = '0;
    fat_links[0] = END_MARK;
  endfunction

  function automatic result_t predict_response(cmd_e c, logic [11:0] cnt, logic [11:0] start);
    result_t     r;
    int          i;
    int          found;
    int          taken;
    int          prev;
    int          idx;
    logic [12:0] v;
    r = '{status: ST_OK, block_index: '0, chain_end: 1'b0};
    case (c)
      CMD_ALLOC: begin
        if (cnt != 0) begin
          found = 0;
          for (i = 1; i < ENTRIES && found < cnt; i++)
            if (fat_links[i] == 0) found++;
          if (found < cnt) begin
            r.status = ST_NO_SPACE;
          end else begin
            taken = 0;
            prev = 0;
            for (i = 1; i < ENTRIES && taken < cnt; i++) begin
              if (fat_links[i] != 0) continue;
              if (taken == 0) r.block_index = i[11:0];
              else fat_links[prev] = i[12:0];
              prev = i;
              taken++;
            end
            fat_links[prev] = END_MARK;
          end
        end
      end
      CMD_FREE: begin
        if (start == 0 || fat_links[start] == 0) begin
          r.status = ST_BAD_ENTRY;
        end else begin
          idx = start;
          for (i = 0; i < cnt; i++) begin
            if (idx == 0 || idx >= ENTRIES) break;
            v = fat_links[idx];
            if (v == 0) break;
            fat_links[idx] = '0;
            if (v == END_MARK) break;
            idx = v;
          end
        end
      end
      CMD_READ: begin
        if (fat_links[start] == 0) r.status = ST_BAD_ENTRY;
        else if (fat_links[start] == END_MARK) r.chain_end = 1'b1;
        else r.block_index = fat_links[start][11:0];
      end
      default: clear_links();
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic add_row(cmd_e c, int cnt, int start, bit typed = 1'b0,
                         status_e st = ST_OK, int idx = 0, bit ce = 1'b0);
    vec_row_t row;
    row.cmd   = c;
    row.cnt   = cnt[11:0];
    row.start = start[11:0];
    row.typed = typed;
    row.resp  = '{status: st, block_index: idx[11:0], chain_end: ce};
    directed_rows.push_back(row);
  endtask

  // called right after a rising edge; returns at the edge that accepts the beat
  task automatic send_cmd(cmd_e c, logic [11:0] cnt, logic [11:0] start,
                          bit typed, result_t typed_resp);
    int      gap;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    block_count_i <= cnt;
    start_block_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_response(c, cnt, start);
    if (c == CMD_ALLOC && r.status == ST_OK && cnt != 0) chain_heads.push_back(r.block_index);
    if (c == CMD_FORMAT) chain_heads.delete();
    expected_responses.push_back(typed ? typed_resp : r);
    n_sent++;
  endtask

  task automatic send_random();
    int          sel;
    int          pick;
    cmd_e        c;
    logic [11:0] cnt;
    logic [11:0] start;
    sel   = $urandom_range(0, 99);
    cnt   = 12'($urandom_range(0, 4095));
    start = 12'($urandom_range(0, 4095));
    if (sel < 2) begin
      c = CMD_FORMAT;
    end else if (sel < 40 || (sel < 70 && chain_heads.size() == 0)) begin
      c = CMD_ALLOC;
      if ($urandom_range(0, 19) != 0) cnt = 12'($urandom_range(1, 24));
    end else if (sel < 70) begin
      c = CMD_FREE;
      pick = $urandom_range(0, chain_heads.size() - 1);
      start = chain_heads[pick];
      chain_heads.delete(pick);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: cnt = 12'($urandom_range(1, 30));
        5, 6, 7:       cnt = 12'hfff;
        default:       ;
      endcase
    end else if (sel < 90) begin
      c = CMD_READ;
      if (chain_heads.size() != 0 && $urandom_range(0, 1) == 1)
        start = 12'(chain_heads[$urandom_range(0, chain_heads.size() - 1)]
                    + $urandom_range(0, 8));
      else if ($urandom_range(0, 1) == 1)
        start = 12'($urandom_range(0, 255));
    end else begin
      c = CMD_FREE;
      if ($urandom_range(0, 1) == 1) start = 12'($urandom_range(0, 255));
    end
    send_cmd(c, cnt, start, 1'b0, '0);
  endtask

  // response checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      case (status_o)
        ST_OK:       n_ok++;
        ST_NO_SPACE: n_nospace++;
        default:     n_bad++;
      endcase
      if (expected_responses.size() == 0) begin
        report_mismatch("outstanding responses", 1, 0);
      end else begin
        want = expected_responses.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (block_index_o != want.block_index)
          report_mismatch("block_index", block_index_o, want.block_index);
        if (chain_end_o != want.chain_end)
          report_mismatch("chain_end", chain_end_o, want.chain_end);
      end
    end
  end

  // response side back-pressure
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #60_000_000;
    $display("tb_block_chain_allocation_table: FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_READ;
    block_count_i = '0;
    start_block_i = '0;
    no_idle       = 1'b0;
    n_errors      = 0;
    n_sent        = 0;
    n_ok          = 0;
    n_nospace     = 0;
    n_bad         = 0;
    clear_links();

    add_row(CMD_READ,   0,    0,    1, ST_OK,        0,    1);
    add_row(CMD_READ,   0,    1,    1, ST_BAD_ENTRY, 0,    0);
    add_row(CMD_READ,   0,    4095, 1, ST_BAD_ENTRY, 0,    0);
    add_row(CMD_FREE,   1,    0,    1, ST_BAD_ENTRY, 0,    0);
    add_row(CMD_FREE,   1,    5,    1, ST_BAD_ENTRY, 0,    0);
    add_row(CMD_ALLOC,  0,    0,    1, ST_OK,        0,    0);
    add_row(CMD_ALLOC,  3,    0,    1, ST_OK,        1,    0);
    add_row(CMD_READ,   0,    1,    1, ST_OK,        2,    0);
    add_row(CMD_READ,   0,    3,    1, ST_OK,        0,    1);
    add_row(CMD_ALLOC,  2,    0,    1, ST_OK,        4,    0);
    add_row(CMD_FREE,   0,    1,    1, ST_OK,        0,    0);
    add_row(CMD_FREE,   1,    2);
    add_row(CMD_ALLOC,  1,    0);
    add_row(CMD_FREE,   4095, 1);
    add_row(CMD_FREE,   2,    3);
    add_row(CMD_ALLOC,  4095, 0,    1, ST_NO_SPACE,  0,    0);
    add_row(CMD_FORMAT, 0,    0,    1, ST_OK,        0,    0);
    add_row(CMD_ALLOC,  4095, 0,    1, ST_OK,        1,    0);
    add_row(CMD_ALLOC,  1,    0,    1, ST_NO_SPACE,  0,    0);
    add_row(CMD_READ,   0,    4095, 1, ST_OK,        0,    1);
    add_row(CMD_READ,   0,    4094, 1, ST_OK,        4095, 0);
    add_row(CMD_FREE,   4095, 4000);
    add_row(CMD_FREE,   10,   1);
    add_row(CMD_FREE,   5,    20);
    add_row(CMD_FREE,   100,  15);
    add_row(CMD_FORMAT, 0,    0,    1, ST_OK,        0,    0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].cnt, directed_rows[i].start,
               directed_rows[i].typed, directed_rows[i].resp);

    for (int i = 0; i < 114; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random();
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("summary: %0d commands sent, %0d mismatches", n_sent, n_errors);
    $display("summary: responses ok %0d, no space %0d, bad entry %0d",
             n_ok, n_nospace, n_bad);
    if (n_errors == 0) begin
      $display("tb_block_chain_allocation_table: PASS");
    end else begin
      $display("tb_block_chain_allocation_table: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcat_pkg.sv
rtl/bcat_table.sv
rtl/bcat_ctrl.sv
rtl/block_chain_allocation_table.sv
bench/tb_block_chain_allocation_table.sv
